[rtl/core/bsm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared constants for the pipelined radix-2 Booth signed multiplier.
// ----------------------------------------------------------------------------
package bsm_pkg;

    localparam int OPND_W = 32;
    localparam int PROD_W = 64;

    typedef logic [OPND_W-1:0] t_opnd;
    typedef logic [PROD_W-1:0] t_prod;

endpackage

[rtl/core/bsm_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_stage
// One registered Booth step: add/subtract on the recoded pair, then shift the
// accumulator:multiplier pair right arithmetically by one.
// ----------------------------------------------------------------------------
module bsm_stage #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [WIDTH+1:0] i_acc,
    input  logic [WIDTH-1:0] i_q,
    input  logic             i_prev,
    input  logic [WIDTH-1:0] i_m,
    output logic             o_valid,
    output logic [WIDTH+1:0] o_acc,
    output logic [WIDTH-1:0] o_q,
    output logic             o_prev,
    output logic [WIDTH-1:0] o_m
);

    import bsm_pkg::*;

    localparam int ACC_W = WIDTH + 2;

    logic             r_valid;
    logic [ACC_W-1:0] r_acc;
    logic [WIDTH-1:0] r_q;
    logic             r_prev;
    logic [WIDTH-1:0] r_m;

    logic [ACC_W-1:0] m_ext;
    logic [ACC_W-1:0] n_sum;
    logic [ACC_W-1:0] n_acc;
    logic [WIDTH-1:0] n_q;

    assign m_ext = {{2{i_m[WIDTH-1]}}, i_m};

    always_comb begin
        unique case ({i_q[0], i_prev})
            2'b10:   n_sum = i_acc - m_ext;
            2'b01:   n_sum = i_acc + m_ext;
            default: n_sum = i_acc;
        endcase
        n_acc = {n_sum[ACC_W-1], n_sum[ACC_W-1:1]};
        n_q   = {n_sum[0], i_q[WIDTH-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_q    <= n_q;
        r_prev <= i_q[0];
        r_m    <= i_m;
    end

    assign o_valid = r_valid;
    assign o_acc   = r_acc;
    assign o_q     = r_q;
    assign o_prev  = r_prev;
    assign o_m     = r_m;

endmodule

[rtl/core/booth_signed_multiplier_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// booth_signed_multiplier_top
// Pipelined radix-2 Booth multiplier giving the exact signed product.
// ----------------------------------------------------------------------------
// A new operand pair is taken every cycle (busy stays low); each product
// appears with o_valid once it has passed the chain of registered stages,
// one pipeline stage per Booth step. Only the low WIDTH bits of each operand are
// used; the 2*WIDTH-bit product is sign-extended to 64 bits. Results are
// shown for one cycle and cannot be held off.
module booth_signed_multiplier_top #(
    parameter int WIDTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  bsm_pkg::t_opnd i_multiplicand,
    input  bsm_pkg::t_opnd i_multiplier,
    output logic           o_valid,
    output bsm_pkg::t_prod o_product
);

    import bsm_pkg::*;

    localparam int ACC_W = WIDTH + 2;

    logic             s_valid [0:WIDTH];
    logic [ACC_W-1:0] s_acc   [0:WIDTH];
    logic [WIDTH-1:0] s_q     [0:WIDTH];
    logic             s_prev  [0:WIDTH];
    logic [WIDTH-1:0] s_m     [0:WIDTH];

    logic signed [2*WIDTH-1:0] prod_nat;

    assign busy       = 1'b0;
    assign s_valid[0] = start;
    assign s_acc[0]   = '0;
    assign s_q[0]     = i_multiplier[WIDTH-1:0];
    assign s_prev[0]  = 1'b0;
    assign s_m[0]     = i_multiplicand[WIDTH-1:0];

    for (genvar g = 0; g < WIDTH; g++) begin : g_step
        bsm_stage #(.WIDTH(WIDTH)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[g]),
            .i_acc   (s_acc[g]),
            .i_q     (s_q[g]),
            .i_prev  (s_prev[g]),
            .i_m     (s_m[g]),
            .o_valid (s_valid[g+1]),
            .o_acc   (s_acc[g+1]),
            .o_q     (s_q[g+1]),
            .o_prev  (s_prev[g+1]),
            .o_m     (s_m[g+1])
        );
    end

    assign prod_nat  = {s_acc[WIDTH][WIDTH-1:0], s_q[WIDTH]};
    assign o_valid   = s_valid[WIDTH];
    assign o_product = PROD_W'(prod_nat);

endmodule

[rtl/core/bsm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_checker
// Port-level checks for the Booth multiplier, bound to the top level.
// ----------------------------------------------------------------------------
module bsm_checker #(
    parameter int WIDTH = 32
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input bsm_pkg::t_opnd i_multiplicand,
    input bsm_pkg::t_opnd i_multiplier,
    input logic           o_valid,
    input bsm_pkg::t_prod o_product
);

    import bsm_pkg::*;

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    a_valid_has_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, WIDTH))
        else $error("result beat without start beat");

    a_zero_mcand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ($past(i_multiplicand[WIDTH-1:0], WIDTH) == '0))
            |-> (o_product == '0))
        else $error("nonzero product for zero multiplicand");

    a_zero_mplier: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ($past(i_multiplier[WIDTH-1:0], WIDTH) == '0))
            |-> (o_product == '0))
        else $error("nonzero product for zero multiplier");

endmodule

bind booth_signed_multiplier_top bsm_checker #(.WIDTH(WIDTH)) u_bsm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_multiplicand (i_multiplicand),
    .i_multiplier   (i_multiplier),
    .o_valid        (o_valid),
    .o_product      (o_product)
);
